>>> hw/rtl/twdb_pkg.sv
`default_nettype none
package twdb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_PWM_LIMIT      = 2'd0;
  localparam logic [1:0] REG_BASE_SPEED     = 2'd1;
  localparam logic [1:0] REG_STEPS_PER_CELL = 2'd2;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam logic [7:0]  PWM_LIMIT_RST      = 8'd255;
  localparam logic [6:0]  BASE_SPEED_RST     = 7'd100;
  localparam logic [15:0] STEPS_PER_CELL_RST = 16'd1000;

  localparam logic [7:0] SPEED_MIN = 8'h80;

  typedef struct packed {
    logic [7:0]  pwm_limit;
    logic [6:0]  base_speed;
    logic [15:0] steps_per_cell;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  cells;
    logic [31:0] left_count;
    logic [31:0] right_count;
  } item_t;

  // speeds are two's complement
  typedef struct packed {
    logic [31:0] origin_left;
    logic [23:0] target_steps;
    logic [7:0]  speed_left;
    logic [7:0]  speed_right;
    logic        moving;
  } state_t;

  typedef struct packed {
    logic [7:0] left_forward_duty;
    logic [7:0] left_reverse_duty;
    logic [7:0] right_forward_duty;
    logic [7:0] right_reverse_duty;
    logic       move_done;
  } result_t;

  // saturating decrement of a signed speed
  function automatic logic [7:0] dec_sat(input logic [7:0] spd);
    logic [7:0] res;
    if (spd == SPEED_MIN) begin
      res = spd;
    end else begin
      res = spd - 8'd1;
    end
    return res;
  endfunction

  // clamp to +/- lim and split: {reverse, forward}
  function automatic logic [15:0] drive(input logic [7:0] spd, input logic [7:0] lim);
    logic signed [9:0] s;
    logic signed [9:0] l;
    logic signed [9:0] c;
    logic signed [9:0] neg;
    logic [15:0] res;
    s = {{2{spd[7]}}, spd};
    l = {2'b00, lim};
    if (s > l) begin
      c = l;
    end else if (s < -l) begin
      c = -l;
    end else begin
      c = s;
    end
    neg = -c;
    if (c > 10'sd0) begin
      res = {8'd0, c[7:0]};
    end else begin
      res = {neg[7:0], 8'd0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/twdb_core.sv
`default_nettype none
module twdb_core (
  input  wire twdb_pkg::cfg_t   cfg,
  input  wire twdb_pkg::item_t  item,
  input  wire twdb_pkg::state_t st,
  output twdb_pkg::state_t      st_nxt,
  output twdb_pkg::result_t     res
);

  logic [23:0] target_prod;
  logic [7:0]  base8;
  logic [31:0] travel;
  logic        reached;
  logic        stopped;
  logic [15:0] drv_l;
  logic [15:0] drv_r;

  assign target_prod = {8'd0, cfg.steps_per_cell} * {16'd0, item.cells};
  assign base8       = {1'b0, cfg.base_speed};
  assign travel      = item.left_count - st.origin_left;
  assign reached     = $signed(travel) >= $signed({8'd0, st.target_steps});

  always_comb begin
    st_nxt  = st;
    stopped = 1'b1;
    if (item.mode == twdb_pkg::MODE_START) begin
      st_nxt.origin_left  = item.left_count;
      st_nxt.target_steps = target_prod;
      st_nxt.speed_left   = base8;
      st_nxt.speed_right  = base8;
      st_nxt.moving       = (target_prod != 24'd0);
      stopped             = (target_prod == 24'd0);
    end else if (st.moving) begin
      if (reached) begin
        st_nxt.moving = 1'b0;
      end else begin
        stopped = 1'b0;
        if ($signed(item.left_count) > $signed(item.right_count)) begin
          // left leads
          if ($signed(st.speed_right) < $signed(base8)) begin
            st_nxt.speed_right = base8;
          end else begin
            st_nxt.speed_left = twdb_pkg::dec_sat(st.speed_left);
          end
        end else if ($signed(item.right_count) > $signed(item.left_count)) begin
          if ($signed(st.speed_left) < $signed(base8)) begin
            st_nxt.speed_left = base8;
          end else begin
            st_nxt.speed_right = twdb_pkg::dec_sat(st.speed_right);
          end
        end
      end
    end
  end

  assign drv_l = twdb_pkg::drive(st_nxt.speed_left, cfg.pwm_limit);
  assign drv_r = twdb_pkg::drive(st_nxt.speed_right, cfg.pwm_limit);

  always_comb begin
    if (stopped) begin
      res = '0;
      res.move_done = 1'b1;
    end else begin
      res.left_forward_duty  = drv_l[7:0];
      res.left_reverse_duty  = drv_l[15:8];
      res.right_forward_duty = drv_r[7:0];
      res.right_reverse_duty = drv_r[15:8];
      res.move_done          = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/two_wheel_distance_balancer.sv
`default_nettype none
// an accepted item passes the input register, then the result register, before result valid
// throughput: one item per cycle while not stalled by out_tready; balance update and clamp
// sit between the input and result registers, state is updated in the same cycle
// reset (rst_n low, synchronous): pipeline empty, no move running, speeds and
// target zero, pwm_limit 255, base_speed 100, steps_per_cell 1000
module two_wheel_distance_balancer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [71:0] in_tdata,   // cells[7:0], left_count[39:8], right_count[71:40]
  input  wire logic        in_tuser,   // mode
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // left_forward_duty, left_reverse_duty,
                                       // right_forward_duty, right_reverse_duty
  output      logic        out_tuser,  // move_done
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  twdb_pkg::cfg_t    cfg_r;
  twdb_pkg::item_t   item_r;
  logic              item_v_r;
  twdb_pkg::state_t  st_r;
  twdb_pkg::state_t  st_nxt;
  twdb_pkg::result_t res_nxt;
  twdb_pkg::result_t res_r;
  logic              out_v_r;
  logic              advance;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !item_v_r || advance;

  twdb_core u_core (
    .cfg    (cfg_r),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_limit      <= twdb_pkg::PWM_LIMIT_RST;
      cfg_r.base_speed     <= twdb_pkg::BASE_SPEED_RST;
      cfg_r.steps_per_cell <= twdb_pkg::STEPS_PER_CELL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        twdb_pkg::REG_PWM_LIMIT:      cfg_r.pwm_limit      <= cfg_wdata[7:0];
        twdb_pkg::REG_BASE_SPEED:     cfg_r.base_speed     <= cfg_wdata[6:0];
        twdb_pkg::REG_STEPS_PER_CELL: cfg_r.steps_per_cell <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_r.mode        <= in_tuser;
      item_r.cells       <= in_tdata[7:0];
      item_r.left_count  <= in_tdata[39:8];
      item_r.right_count <= in_tdata[71:40];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= item_v_r;
      if (item_v_r) begin
        st_r <= st_nxt;
      end
    end
    if (advance && item_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r.right_reverse_duty, res_r.right_forward_duty,
                       res_r.left_reverse_duty, res_r.left_forward_duty};
  assign out_tuser  = res_r.move_done;

  // a finished move always shows zero drive
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("done result with nonzero drive");

  // a running move has a nonzero target
  a_moving_target: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.moving |-> st_r.target_steps != 24'd0)
    else $error("move running with zero target");

  // a wheel never drives both channels
  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == 8'd0 || out_tdata[15:8] == 8'd0) &&
                   (out_tdata[23:16] == 8'd0 || out_tdata[31:24] == 8'd0))
    else $error("forward and reverse duty both set");

  // an accepted item lands in the input register
  a_item_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> item_v_r)
    else $error("accepted item lost");

endmodule
`default_nettype wire
